>>> design/pulse_count_frequency_meter_macros.svh
// Assertion macros shared by the pulse counter frequency meter modules.
// Depends on nothing; include by bare file name.
`ifndef PULSE_COUNT_FREQUENCY_METER_MACROS_SVH
`define PULSE_COUNT_FREQUENCY_METER_MACROS_SVH
// assert that a implies b at the same edge
`define PCFM_ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication failed");
// assert that a implies b at the next edge
`define PCFM_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle implication failed");
`endif

>>> design/pcfm_pkg.sv
// Package for the pulse counter frequency meter: widths, mode codes, commands.
// Used by the controller, datapath and top level.
`default_nettype none
package pcfm_pkg;
   localparam int CHANNELS = 8;
   localparam int CH_W     = 3;
   localparam int CNT_BITS = 32;

   localparam logic [1:0] MODE_EDGE   = 2'd0;
   localparam logic [1:0] MODE_POLL   = 2'd1;
   localparam logic [1:0] MODE_REPORT = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] CSR_MIN_INT   = 3'd0;
   localparam logic [2:0] CSR_REP_EN    = 3'd1;
   localparam logic [2:0] CSR_ACT_LVL   = 3'd2;
   localparam logic [2:0] CSR_FSCALE    = 3'd3;
   localparam logic [2:0] CSR_FOFFSET   = 3'd4;
   localparam logic [2:0] CSR_CSCALE    = 3'd5;
   localparam logic [2:0] CSR_COFFSET   = 3'd6;

   localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
   localparam logic [19:0] ONE_MILLION = 20'd1000000;

   typedef struct packed {
      logic load;      // latch item, compute first step
      logic div_start; // start divider
      logic mul_step;  // advance multiply stage
      logic finish;    // form result
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic need_div;  // report path with frequency computed
      logic mul_last;
      logic has_rsp;
   } sts_type;
endpackage
`default_nettype wire

>>> design/pcfm_ctrl.sv
// Controller state machine for the pulse counter frequency meter.
// Depends on pcfm_pkg and the macros header.
`default_nettype none
`include "pulse_count_frequency_meter_macros.svh"
module pcfm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pcfm_pkg::cmd_type      cmd,
   input  wire pcfm_pkg::sts_type sts
);
   import pcfm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_LOAD = 6'b000010,
      S_DIV  = 6'b000100,
      S_MUL  = 6'b001000,
      S_FIN  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            if (!sts.div_busy) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (sts.mul_last) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = sts.has_rsp ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_valid = (state_ff == S_OUT);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   `PCFM_ASSERT_IMPLY(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `PCFM_ASSERT_IMPLY(a_excl, clock, reset, in_ready, !out_valid)
   `PCFM_ASSERT_NEXT(a_hold, clock, reset, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

>>> design/pcfm_datapath.sv
// Datapath: per-channel state, 64/32 restoring divider, shared multiplier.
// Depends on pcfm_pkg and the macros header.
`default_nettype none
`include "pulse_count_frequency_meter_macros.svh"
module pcfm_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcfm_pkg::cmd_type cmd,
   output pcfm_pkg::sts_type      sts,
   input  wire logic [1:0]        in_mode,
   input  wire logic [2:0]        in_channel,
   input  wire logic [31:0]       in_time,
   input  wire logic              in_level,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_idx,
   input  wire logic [31:0]       csr_data,
   output logic [2:0]             o_channel,
   output logic                   o_sv,
   output logic                   o_st,
   output logic                   o_fv,
   output logic [47:0]            o_fval,
   output logic                   o_cv,
   output logic [47:0]            o_cval
);
   import pcfm_pkg::*;

   logic [31:0] min_int_ff;
   logic [2:0]  rep_en_ff;
   logic        act_ff;
   logic [31:0] fscale_ff, foff_ff, cscale_ff, coff_ff;

   logic [31:0] cnt_ff   [CHANNELS];
   logic [31:0] clr_ff   [CHANNELS];
   logic [31:0] lst_ff   [CHANNELS];
   logic [31:0] lrt_ff   [CHANNELS];
   logic [CHANNELS-1:0] pend_ff;

   logic [2:0]  ch_ff;
   logic        sv_ff, st_ff, fv_ff, cv_ff;
   logic        rep_ff;
   logic [31:0] dt_ff, cnt_snap_ff;
   logic [63:0] num_ff;     // divider dividend: count difference times one million
   logic [32:0] rem_ff;
   logic [63:0] quo_ff;
   logic [6:0]  div_cnt_ff;
   logic        div_busy_ff;
   logic [1:0]  mstep_ff;
   logic signed [85:0] fprod_ff;
   logic signed [65:0] cprod_ff;
   logic signed [47:0] fval_ff, cval_ff;

   wire [2:0]  ch  = in_channel;
   wire        chok = ({29'd0, ch} < 32'(CHANNELS));
   wire [31:0] lst = cnt_ff[ch];
   wire [31:0] cnt_diff = lst - clr_ff[ch];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_int_ff <= 32'd200000;
         rep_en_ff  <= 3'd0;
         act_ff     <= 1'b1;
         fscale_ff  <= 32'd65536;
         foff_ff    <= 32'd0;
         cscale_ff  <= 32'd65536;
         coff_ff    <= 32'd0;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_MIN_INT: min_int_ff <= csr_data;
            CSR_REP_EN:  rep_en_ff  <= csr_data[2:0];
            CSR_ACT_LVL: act_ff     <= csr_data[0];
            CSR_FSCALE:  fscale_ff  <= csr_data;
            CSR_FOFFSET: foff_ff    <= csr_data;
            CSR_CSCALE:  cscale_ff  <= csr_data;
            CSR_COFFSET: coff_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // load: apply state updates, decide which parts follow
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            cnt_ff[i] <= '0; clr_ff[i] <= '0; lst_ff[i] <= '0; lrt_ff[i] <= '0;
         end
         pend_ff <= '0;
         sv_ff <= 1'b0; st_ff <= 1'b0; fv_ff <= 1'b0; cv_ff <= 1'b0; rep_ff <= 1'b0;
      end else if (cmd.load) begin
         ch_ff <= ch;
         sv_ff <= 1'b0; st_ff <= 1'b0; fv_ff <= 1'b0; cv_ff <= 1'b0; rep_ff <= 1'b0;
         cnt_snap_ff <= lst;
         if (chok) begin
            case (in_mode)
               MODE_EDGE: begin
                  cnt_ff[ch]  <= lst + 32'd1;
                  pend_ff[ch] <= 1'b1;
               end
               MODE_POLL: begin
                  if (pend_ff[ch]) begin
                     if (in_time < lst_ff[ch]) lst_ff[ch] <= in_time;
                     else if (in_time - lst_ff[ch] >= min_int_ff) begin
                        lst_ff[ch]  <= in_time;
                        pend_ff[ch] <= 1'b0;
                        sv_ff <= rep_en_ff[0];
                        st_ff <= rep_en_ff[0] & (in_level == act_ff);
                     end
                  end
               end
               MODE_REPORT: begin
                  sv_ff <= rep_en_ff[0];
                  st_ff <= rep_en_ff[0] & (in_level == act_ff);
                  cv_ff <= rep_en_ff[2];
                  if (rep_en_ff[1]) begin
                     lrt_ff[ch] <= in_time;
                     if (in_time <= lrt_ff[ch]) begin
                        cv_ff <= 1'b0;
                     end else begin
                        fv_ff <= 1'b1;
                        rep_ff <= 1'b1;
                        dt_ff <= in_time - lrt_ff[ch];
                        num_ff <= 64'(cnt_diff) * 64'(ONE_MILLION);
                        clr_ff[ch] <= lst;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= 7'd64;
         rem_ff      <= '0;
         quo_ff      <= num_ff;
      end else if (div_busy_ff) begin
         logic [32:0] r;
         r = {rem_ff[31:0], quo_ff[63]};
         if (r >= {1'b0, dt_ff}) begin
            rem_ff <= r - {1'b0, dt_ff};
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= r;
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff - 7'd1;
         if (div_cnt_ff == 7'd1) div_busy_ff <= 1'b0;
      end
   end

   // q < 2^52; split q*scale into two 26x32 partial products
   logic signed [33:0] fsc_s;
   logic signed [33:0] csc_s;
   logic signed [26:0] qlo_s, qhi_s;
   logic signed [60:0] fpart;
   logic signed [65:0] cpart;
   assign fsc_s = 34'(signed'(fscale_ff));
   assign csc_s = 34'(signed'(cscale_ff));
   assign qlo_s = signed'({1'b0, quo_ff[25:0]});
   assign qhi_s = signed'({1'b0, quo_ff[51:26]});
   assign fpart = ((mstep_ff == 2'd0) ? qlo_s : qhi_s) * fsc_s;
   assign cpart = signed'({1'b0, cnt_snap_ff[31:1]}) * csc_s;
   always_ff @(posedge clock) begin
      if (reset) mstep_ff <= '0;
      else if (cmd.load) mstep_ff <= '0;
      else if (cmd.mul_step) begin
         mstep_ff <= mstep_ff + 2'd1;
         case (mstep_ff)
            2'd0: fprod_ff <= 86'(fpart);
            2'd1: fprod_ff <= fprod_ff + (86'(fpart) <<< 26);
            2'd2: cprod_ff <= cpart;
            default: ;
         endcase
      end
   end

   function automatic logic signed [47:0] sat(input logic signed [87:0] v);
      if (v > 88'(MAX48)) sat = MAX48;
      else if (v < 88'(MIN48)) sat = MIN48;
      else sat = v[47:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         fval_ff <= sat(88'(fprod_ff >>> 1) + 88'(signed'(foff_ff)));
         cval_ff <= sat(88'(cprod_ff) + 88'(signed'(coff_ff)));
      end
   end

   assign sts.div_busy = div_busy_ff;
   assign sts.need_div = rep_ff;
   assign sts.mul_last = (mstep_ff == 2'd2);
   assign sts.has_rsp  = sv_ff | fv_ff | cv_ff;

   assign o_channel = ch_ff;
   assign o_sv   = sv_ff;
   assign o_st   = st_ff;
   assign o_fv   = fv_ff;
   assign o_fval = fv_ff ? fval_ff : 48'd0;
   assign o_cv   = cv_ff;
   assign o_cval = cv_ff ? cval_ff : 48'd0;

   `PCFM_ASSERT_NEXT(a_div_start, clock, reset, cmd.div_start, div_busy_ff)
   `PCFM_ASSERT_IMPLY(a_fv_rep, clock, reset, fv_ff, rep_ff)
   `PCFM_ASSERT_IMPLY(a_st_sv, clock, reset, st_ff, sv_ff)
endmodule
`default_nettype wire

>>> design/pulse_count_frequency_meter.sv
// Channel       Dir  Fields (lsb first)
// req_          in   tdata: mode, channel, time_us, pin_level
// rsp_          out  tdata: out_channel, state_valid, state_true, freq_valid,
//                           freq_value, count_valid, count_value
// csr_          in   we, idx, data
// An item passes the load, multiply and finish states, one at a time; a report
// with frequency runs the bit-serial divider between load and multiply. Reset
// is synchronous and clears all channel state. A result holds until
// rsp_tready; no item is taken meanwhile.
`default_nettype none
module pulse_count_frequency_meter (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,  // mode, channel, time_us, pin_level
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,  // out_channel..count_value, zero pad
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_idx,
   input  wire logic [31:0]  csr_data
);
   import pcfm_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [2:0]  o_ch;
   logic        o_sv, o_st, o_fv, o_cv;
   logic [47:0] o_fv_val, o_cv_val;

   pcfm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd(cmd), .sts(sts)
   );

   pcfm_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_mode(req_tdata[1:0]), .in_channel(req_tdata[4:2]),
      .in_time(req_tdata[36:5]), .in_level(req_tdata[37]),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_data(csr_data),
      .o_channel(o_ch), .o_sv(o_sv), .o_st(o_st), .o_fv(o_fv),
      .o_fval(o_fv_val), .o_cv(o_cv), .o_cval(o_cv_val)
   );

   assign rsp_tdata = {1'b0, o_cv_val, o_cv, o_fv_val, o_fv, o_st, o_sv, o_ch};
endmodule
`default_nettype wire

>>> test/tb_pulse_count_frequency_meter.sv
// Testbench for pulse_count_frequency_meter: directed table then random items,
// each result checked field by field against an in-bench channel predictor.
// Depends on pcfm_pkg and the RTL top level.
`timescale 1ns / 100ps
module tb_pulse_count_frequency_meter;
   import pcfm_pkg::*;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  channel;
      logic [31:0] time_us;
      logic        pin_level;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         ch;
      logic               sv, st, fv, cv;
      logic signed [47:0] fval, cval;
   } meter_word_type;

   typedef struct {
      req_word_type   w;
      logic           has_exp;
      meter_word_type e;
   } row_type;

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [39:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [103:0] rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_idx;
   logic [31:0]  csr_data;

   pulse_count_frequency_meter dut (.*);

   // shadow registers and channel state
   logic [31:0]        min_int;
   logic [2:0]         rep_en;
   logic               act_lvl;
   logic signed [31:0] fscale, foffset, cscale, coffset;
   logic [31:0]        edges [CHANNELS];
   logic [31:0]        edges_at_rep [CHANNELS];
   logic [31:0]        state_t [CHANNELS];
   logic [31:0]        rep_t [CHANNELS];
   logic               pending [CHANNELS];

   meter_word_type meter_q[$];
   meter_word_type typed_q[$];
   int  errors = 0, n_items = 0, n_rsp = 0;
   logic quiet = 0, rsp_stall_on = 1;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic signed [47:0] sat48(logic signed [127:0] v);
      if (v > 128'sd140737488355327) return MAX48;
      if (v < -128'sd140737488355328) return MIN48;
      return v[47:0];
   endfunction

   // floor(q*scale/2)+offset in wide arithmetic gives the same saturated value
   function automatic logic signed [47:0] freq_scaled(logic [63:0] q);
      logic signed [127:0] p;
      p = $signed({64'd0, q}) * $signed({{96{fscale[31]}}, fscale});
      p = p >>> 1;
      return sat48(p + $signed({{96{foffset[31]}}, foffset}));
   endfunction

   function automatic logic meter_predict(req_word_type w, output meter_word_type r);
      logic [31:0] dt, diff;
      logic [63:0] q;
      logic        skip;
      logic signed [127:0] c;
      r = '{default: 0};
      r.ch = w.channel;
      skip = 0;
      case (w.mode)
         MODE_EDGE: begin
            edges[w.channel]++;
            pending[w.channel] = 1;
            return 0;
         end
         MODE_POLL: begin
            if (!pending[w.channel]) return 0;
            if (w.time_us < state_t[w.channel]) begin
               state_t[w.channel] = w.time_us;
               return 0;
            end
            if (w.time_us - state_t[w.channel] < min_int) return 0;
            state_t[w.channel] = w.time_us;
            pending[w.channel] = 0;
            if (!rep_en[0]) return 0;
            r.sv = 1;
            r.st = w.pin_level == act_lvl;
            return 1;
         end
         MODE_REPORT: begin
            if (rep_en[0]) begin
               r.sv = 1;
               r.st = w.pin_level == act_lvl;
            end
            if (rep_en[1]) begin
               if (w.time_us <= rep_t[w.channel]) begin
                  rep_t[w.channel] = w.time_us;
                  skip = 1;
               end else begin
                  dt = w.time_us - rep_t[w.channel];
                  diff = edges[w.channel] - edges_at_rep[w.channel];
                  q = (64'(diff) * 64'd1000000) / 64'(dt);
                  r.fv = 1;
                  r.fval = freq_scaled(q);
                  edges_at_rep[w.channel] = edges[w.channel];
                  rep_t[w.channel] = w.time_us;
               end
            end
            if (!skip && rep_en[2]) begin
               c = $signed({97'd0, edges[w.channel][31:1]})
                  * $signed({{96{cscale[31]}}, cscale})
                  + $signed({{96{coffset[31]}}, coffset});
               r.cv = 1;
               r.cval = sat48(c);
            end
            return r.sv | r.fv | r.cv;
         end
         default: return 0;
      endcase
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_we = 1;
      csr_idx = idx;
      csr_data = val;
      @(negedge clock);
      csr_we = 0;
      case (idx)
         CSR_MIN_INT: min_int = val;
         CSR_REP_EN:  rep_en = val[2:0];
         CSR_ACT_LVL: act_lvl = val[0];
         CSR_FSCALE:  fscale = val;
         CSR_FOFFSET: foffset = val;
         CSR_CSCALE:  cscale = val;
         default:     coffset = val;
      endcase
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (meter_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic send(req_word_type w, logic has_exp = 0,
                       meter_word_type e = '{default: 0});
      meter_word_type r;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {w.pin_level, w.time_us, w.channel, w.mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (meter_predict(w, r)) begin
         if (has_exp) typed_q.push_back(e);
         meter_q.push_back(r);
      end
      n_items++;
      @(negedge clock);
   endtask

   // receiver stalls
   initial begin
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         if (!quiet && rsp_stall_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      meter_word_type a, e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.ch = rsp_tdata[2:0];
         a.sv = rsp_tdata[3];
         a.st = rsp_tdata[4];
         a.fv = rsp_tdata[5];
         a.fval = rsp_tdata[53:6];
         a.cv = rsp_tdata[54];
         a.cval = rsp_tdata[102:55];
         n_rsp++;
         if (meter_q.size() == 0) begin
            $error("word with no expectation waiting");
            errors++;
         end else begin
            e = meter_q.pop_front();
            if (typed_q.size() != 0 && a.ch == typed_q[0].ch) begin
               if (typed_q[0] != e) begin
                  $error("table row disagrees with predictor");
                  errors++;
               end
               void'(typed_q.pop_front());
            end
            if (a.ch != e.ch) begin $error("out_channel exp %0d got %0d", e.ch, a.ch); errors++; end
            if (a.sv != e.sv) begin $error("state_valid exp %0d got %0d", e.sv, a.sv); errors++; end
            if (a.st != e.st) begin $error("state_true exp %0d got %0d", e.st, a.st); errors++; end
            if (a.fv != e.fv) begin $error("freq_valid exp %0d got %0d", e.fv, a.fv); errors++; end
            if (a.fval != e.fval) begin
               $error("freq_value exp %0d got %0d", e.fval, a.fval); errors++;
            end
            if (a.cv != e.cv) begin $error("count_valid exp %0d got %0d", e.cv, a.cv); errors++; end
            if (a.cval != e.cval) begin
               $error("count_value exp %0d got %0d", e.cval, a.cval); errors++;
            end
         end
      end
   end

   function automatic req_word_type rw(logic [1:0] m, logic [2:0] c, logic [31:0] t, logic l);
      rw = '{mode: m, channel: c, time_us: t, pin_level: l};
   endfunction

   function automatic meter_word_type ew(logic [2:0] c, logic sv, logic st);
      ew = '{ch: c, sv: sv, st: st, fv: 0, fval: 0, cv: 0, cval: 0};
   endfunction

   initial begin
      row_type      tbl[$];
      req_word_type w;
      logic [31:0]  now [CHANNELS];
      int           k;
      min_int = 200000; rep_en = 0; act_lvl = 1;
      fscale = 65536; foffset = 0; cscale = 65536; coffset = 0;
      for (int i = 0; i < CHANNELS; i++) begin
         edges[i] = 0; edges_at_rep[i] = 0; state_t[i] = 0; rep_t[i] = 0;
         pending[i] = 0; now[i] = 0;
      end
      reset = 1; req_tvalid = 0; req_tdata = 0;
      csr_we = 0; csr_idx = CSR_MIN_INT; csr_data = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset values: report disabled, polls consume pending silently
      tbl.push_back('{rw(MODE_EDGE, 0, 0, 0), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_POLL, 0, 300000, 1), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_UNUSED, 1, 32'hFFFF_FFFF, 1), 0, ew(0, 0, 0)});
      foreach (tbl[i]) send(tbl[i].w, tbl[i].has_exp, tbl[i].e);
      drain();
      tbl.delete();
      csr_write(CSR_REP_EN, 3'd7);
      csr_write(CSR_MIN_INT, 32'd0);
      tbl.push_back('{rw(MODE_POLL, 2, 5, 1), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_EDGE, 2, 0, 0), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_POLL, 2, 5, 1), 1, ew(2, 1, 1)});
      tbl.push_back('{rw(MODE_EDGE, 3, 0, 0), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_POLL, 3, 32'hFFFF_FFFF, 0), 1, ew(3, 1, 0)});
      tbl.push_back('{rw(MODE_EDGE, 3, 0, 0), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_POLL, 3, 7, 0), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_POLL, 3, 7, 1), 1, ew(3, 1, 1)});
      for (int i = 0; i < 4; i++) tbl.push_back('{rw(MODE_EDGE, 7, 0, i[0]), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_REPORT, 7, 1000000, 1), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_REPORT, 7, 1000000, 0), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_REPORT, 7, 1000001, 1), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_REPORT, 6, 0, 1), 0, ew(0, 0, 0)});
      tbl.push_back('{rw(MODE_REPORT, 6, 32'hFFFF_FFFF, 1), 0, ew(0, 0, 0)});
      foreach (tbl[i]) send(tbl[i].w, tbl[i].has_exp, tbl[i].e);
      drain();

      // random phases, each with a fresh register setting
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_MIN_INT, ph == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 3000));
         csr_write(CSR_REP_EN, ph < 7 ? $urandom_range(0, 7) : 3'd7);
         csr_write(CSR_ACT_LVL, $urandom_range(0, 1));
         csr_write(CSR_FSCALE, ph == 1 ? 32'h8000_0000 : ph == 2 ? 32'h7FFF_FFFF : $urandom);
         csr_write(CSR_FOFFSET, ph == 1 ? 32'h8000_0000 : ph == 2 ? 32'h7FFF_FFFF : $urandom);
         csr_write(CSR_CSCALE, ph == 3 ? 32'h8000_0000 : ph == 4 ? 32'h7FFF_FFFF
                               : ph == 5 ? 32'd0 : $urandom);
         csr_write(CSR_COFFSET, ph == 3 ? 32'h8000_0000 : ph == 4 ? 32'h7FFF_FFFF : $urandom);
         if (ph == 6) quiet = 1;
         for (int i = 0; i < 104; i++) begin
            k = $urandom_range(0, 99);
            w.channel = $urandom_range(0, 7);
            w.pin_level = $urandom_range(0, 1);
            if (k < 50) begin
               w.mode = MODE_EDGE;
               w.time_us = $urandom;
            end else begin
               w.mode = k < 70 ? MODE_POLL : k < 97 ? MODE_REPORT : MODE_UNUSED;
               if (k % 13 == 0) now[w.channel] = $urandom;
               else now[w.channel] += $urandom_range(0, 5000);
               w.time_us = now[w.channel];
            end
            send(w);
         end
         drain();
      end
      drain();
      $display("covered %0d request words, %0d result words over 8 register settings",
               n_items, n_rsp);
      if (errors == 0 && meter_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (meter_q.size() != 0) $error("%0d expected words never arrived", meter_q.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+design
design/pcfm_pkg.sv
design/pcfm_ctrl.sv
design/pcfm_datapath.sv
design/pulse_count_frequency_meter.sv
test/tb_pulse_count_frequency_meter.sv
